// ===== design/lru_miss_counter_macros.svh =====
// assertion macros for the lru miss counter
// used by the top level, expects aclk and aresetn in scope
`ifndef LRU_MISS_COUNTER_MACROS_SVH
`define LRU_MISS_COUNTER_MACROS_SVH

// condition that holds at every edge out of reset
`define LMC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// antecedent at one edge implies consequent at the next edge
`define LMC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/lmc_pkg.sv =====
// shared constants and types for the lru miss counter
// no dependencies
package lmc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int KEY_W       = 32;
    localparam int CAP_W       = 5;
    localparam int COUNT_W     = 32;
    localparam int USED_W      = 5;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int RANK_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IDX_W       = RANK_W;
    localparam int S_DATA_W    = 32;
    localparam int M_DATA_W    = 40;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    typedef enum logic [1:0] {
        ST_EMPTY = 2'b01,
        ST_HOLD  = 2'b10
    } state_t;

    typedef struct packed {
        logic take;
    } cmd_t;

endpackage

// ===== design/lmc_ctrl.sv =====
// controller for the lru miss counter: output register occupancy and accept
// depends on lmc_pkg
module lmc_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output lmc_pkg::cmd_t cmd
);

    lmc_pkg::state_t state_reg;
    lmc_pkg::state_t state_next;
    logic            take;

    assign s_tready = (state_reg == lmc_pkg::ST_EMPTY) || m_tready;
    assign take     = s_tvalid && s_tready;
    assign m_tvalid = (state_reg == lmc_pkg::ST_HOLD);
    assign cmd.take = take;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lmc_pkg::ST_EMPTY: begin
                if (take) state_next = lmc_pkg::ST_HOLD;
            end
            lmc_pkg::ST_HOLD: begin
                if (m_tready && !take) state_next = lmc_pkg::ST_EMPTY;
            end
            default: state_next = lmc_pkg::ST_EMPTY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lmc_pkg::ST_EMPTY;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/lmc_datapath.sv =====
// datapath for the lru miss counter: entry store, parallel lookup, recency update
// depends on lmc_pkg
module lmc_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lmc_pkg::cmd_t                 cmd,
    input  logic                          cfg_wr_en,
    input  logic [lmc_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic [lmc_pkg::KEY_W-1:0]     key,
    input  logic                          start_sequence,
    output logic                          hit,
    output logic [lmc_pkg::COUNT_W-1:0]   miss_count,
    output logic [lmc_pkg::USED_W-1:0]    entries_used
);

    localparam int N = lmc_pkg::MAX_ENTRIES;

    logic [lmc_pkg::CAP_W-1:0]   cap_reg;
    logic [lmc_pkg::KEY_W-1:0]   key_reg [N];
    logic [N-1:0]                valid_reg;
    logic [lmc_pkg::RANK_W-1:0]  rank_reg [N];
    logic [lmc_pkg::CNT_W-1:0]   used_reg;
    logic [lmc_pkg::COUNT_W-1:0] miss_reg;
    logic                        hit_out_reg;
    logic [lmc_pkg::COUNT_W-1:0] miss_out_reg;
    logic [lmc_pkg::USED_W-1:0]  used_out_reg;

    logic [N-1:0]                valid_cur;
    logic [lmc_pkg::CNT_W-1:0]   used_cur;
    logic [lmc_pkg::COUNT_W-1:0] miss_cur;
    logic [lmc_pkg::CNT_W-1:0]   cap_eff;
    logic                        cap_nz;
    logic                        hit_now;
    logic [lmc_pkg::IDX_W-1:0]   hit_idx;
    logic [lmc_pkg::RANK_W-1:0]  hit_rank;
    logic [lmc_pkg::IDX_W-1:0]   free_idx;
    logic                        free_found;
    logic [lmc_pkg::IDX_W-1:0]   victim_idx;
    logic                        victim_found;
    logic                        full;
    logic                        do_update;
    logic [lmc_pkg::CNT_W-1:0]   limit;
    logic [lmc_pkg::IDX_W-1:0]   slot;
    logic [lmc_pkg::RANK_W-1:0]  rank_next [N];
    logic [N-1:0]                valid_next;
    logic [lmc_pkg::CNT_W-1:0]   used_next;
    logic [lmc_pkg::COUNT_W-1:0] miss_next;

    always_comb begin
        valid_cur = start_sequence ? '0 : valid_reg;
        used_cur  = start_sequence ? '0 : used_reg;
        miss_cur  = start_sequence ? '0 : miss_reg;

        if (32'(cap_reg) > 32'(N)) cap_eff = lmc_pkg::CNT_W'(N);
        else                       cap_eff = lmc_pkg::CNT_W'(cap_reg);
        cap_nz = (cap_reg != '0);

        // first matching, first free and least recent entry
        hit_now      = 1'b0;
        hit_idx      = '0;
        hit_rank     = '0;
        free_found   = 1'b0;
        free_idx     = '0;
        victim_found = 1'b0;
        victim_idx   = '0;
        for (int i = 0; i < N; i++) begin
            if (cap_nz && valid_cur[i] && key_reg[i] == key && !hit_now) begin
                hit_now  = 1'b1;
                hit_idx  = lmc_pkg::IDX_W'(i);
                hit_rank = rank_reg[i];
            end
            if (!valid_cur[i] && !free_found) begin
                free_found = 1'b1;
                free_idx   = lmc_pkg::IDX_W'(i);
            end
            if (valid_cur[i] && !victim_found
                    && lmc_pkg::CNT_W'(rank_reg[i]) + 1'b1 == used_cur) begin
                victim_found = 1'b1;
                victim_idx   = lmc_pkg::IDX_W'(i);
            end
        end

        full      = (used_cur >= cap_eff);
        do_update = hit_now || cap_nz;

        if (hit_now) begin
            limit = lmc_pkg::CNT_W'(hit_rank);
            slot  = hit_idx;
        end else if (full) begin
            limit = used_cur - 1'b1;
            slot  = victim_idx;
        end else begin
            limit = used_cur;
            slot  = free_idx;
        end

        valid_next = valid_cur;
        for (int i = 0; i < N; i++) begin
            rank_next[i] = rank_reg[i];
            if (do_update && valid_cur[i] && lmc_pkg::CNT_W'(rank_reg[i]) < limit) begin
                rank_next[i] = rank_reg[i] + 1'b1;
            end
            if (do_update && slot == lmc_pkg::IDX_W'(i)) begin
                rank_next[i]  = '0;
                valid_next[i] = 1'b1;
            end
        end

        used_next = (!hit_now && cap_nz && !full) ? used_cur + 1'b1 : used_cur;

        if (hit_now || miss_cur == '1) miss_next = miss_cur;
        else                           miss_next = miss_cur + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= lmc_pkg::CAP_RESET;
            valid_reg <= '0;
            used_reg  <= '0;
            miss_reg  <= '0;
            for (int i = 0; i < N; i++) begin
                rank_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) cap_reg <= cfg_wr_data;
            if (cmd.take) begin
                valid_reg <= valid_next;
                used_reg  <= used_next;
                miss_reg  <= miss_next;
                for (int i = 0; i < N; i++) begin
                    rank_reg[i] <= rank_next[i];
                end
            end
        end
    end

    // key store and result register, no reset
    always_ff @(posedge aclk) begin
        for (int i = 0; i < N; i++) begin
            if (cmd.take && !hit_now && cap_nz && slot == lmc_pkg::IDX_W'(i)) begin
                key_reg[i] <= key;
            end
        end
        if (cmd.take) begin
            hit_out_reg  <= hit_now;
            miss_out_reg <= miss_next;
            used_out_reg <= lmc_pkg::USED_W'(used_next);
        end
    end

    assign hit          = hit_out_reg;
    assign miss_count   = miss_out_reg;
    assign entries_used = used_out_reg;

endmodule

// ===== design/lru_miss_counter.sv =====
// lru miss counter top level: controller, datapath and assertions
// depends on lmc_pkg, lmc_ctrl, lmc_datapath and lru_miss_counter_macros.svh
//
// usage
//  s_ channel carries one request: tdata holds the key, tuser the start flag
//  that empties the cache and clears the miss count before this access
//  m_ channel returns one result per request: tuser is the hit flag, tdata
//  holds the running miss count and the number of entries in use
//  cfg_wr_en / cfg_wr_data write the capacity in use (0 to 16, above 16 acts
//  as 16, 0 makes every access a miss); write only while idle
//  latency: result valid one cycle after the request is accepted
//  throughput: one request per cycle, set by the single-cycle parallel compare
//  and recency update over the 16 registered entries
//  a held result does not block the next request when m_tready is high in the
//  same cycle; while m_tready is low with a result held, s_tready is low
//  reset empties the cache, clears the miss count and sets capacity to 16
`include "lru_miss_counter_macros.svh"

module lru_miss_counter (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lmc_pkg::S_DATA_W-1:0]   s_tdata,   // [31:0] key
    input  logic                           s_tuser,   // [0] start_sequence
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lmc_pkg::M_DATA_W-1:0]   m_tdata,   // [31:0] miss_count, [36:32] entries_used
    output logic                           m_tuser,   // [0] hit
    input  logic                           cfg_wr_en,
    input  logic [lmc_pkg::CAP_W-1:0]      cfg_wr_data
);

    lmc_pkg::cmd_t                 cmd;
    logic [lmc_pkg::COUNT_W-1:0]   miss_count;
    logic [lmc_pkg::USED_W-1:0]    entries_used;

    lmc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    lmc_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .key            (s_tdata[lmc_pkg::KEY_W-1:0]),
        .start_sequence (s_tuser),
        .hit            (m_tuser),
        .miss_count     (miss_count),
        .entries_used   (entries_used)
    );

    assign m_tdata = {
        {(lmc_pkg::M_DATA_W - lmc_pkg::COUNT_W - lmc_pkg::USED_W){1'b0}},
        entries_used,
        miss_count
    };

    `LMC_ASSERT_ALWAYS(a_used_bound, !m_tvalid || 32'(entries_used) <= 32'(lmc_pkg::MAX_ENTRIES), "entries in use above maximum")
    `LMC_ASSERT_ALWAYS(a_hit_nonempty, !(m_tvalid && m_tuser) || entries_used != '0, "hit reported with empty cache")
    `LMC_ASSERT_NEXT(a_accept_result, aresetn && s_tvalid && s_tready, m_tvalid, "accepted request gave no result")

endmodule

// ===== bench/lru_miss_counter_check.sv =====
// request/result checker for the lru miss counter: mirrors the cache contents,
// recency order and miss count, and compares every result with its prediction
// depends on lmc_pkg
module lru_miss_counter_check
    import lmc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                m_tuser,
    input  logic                cfg_wr_en,
    input  logic [CAP_W-1:0]    cfg_wr_data,
    output int                  fail_count,
    output int                  pending_results
);

    localparam int EXP_DEPTH = 8;

    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] miss_count;
        logic [USED_W-1:0]  entries_used;
    } access_result_t;

    logic [KEY_W-1:0]   key_store [MAX_ENTRIES];
    logic               slot_live [MAX_ENTRIES];
    int unsigned        slot_age  [MAX_ENTRIES];
    int unsigned        live_count;
    logic [COUNT_W-1:0] miss_tally;
    logic [CAP_W-1:0]   capacity;
    access_result_t     expected_results [EXP_DEPTH];
    int                 exp_head;
    int                 exp_tail;
    int                 exp_count;
    int                 fail_tally = 0;

    assign fail_count = fail_tally;

    function automatic void clear_entries();
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            key_store[i] = '0;
            slot_live[i] = 1'b0;
            slot_age[i]  = 0;
        end
        live_count = 0;
    endfunction

    // every live entry younger than limit gets one step older
    function automatic void age_younger(int unsigned limit);
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (slot_live[i] && slot_age[i] < limit) begin
                slot_age[i]++;
            end
        end
    endfunction

    function automatic access_result_t access_cache(logic [KEY_W-1:0] key, logic start);
        int unsigned    cap;
        int             slot;
        logic           found;
        access_result_t res;
        cap   = (capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity;
        found = 1'b0;
        slot  = 0;
        if (start) begin
            clear_entries();
            miss_tally = '0;
        end
        if (cap != 0) begin
            for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
                if (slot_live[i] && key_store[i] == key) begin
                    found = 1'b1;
                    slot  = i;
                end
            end
        end
        if (found) begin
            age_younger(slot_age[slot]);
            slot_age[slot] = 0;
        end else begin
            if (miss_tally != '1) begin
                miss_tally++;
            end
            if (cap != 0) begin
                if (live_count >= cap) begin
                    // replace the oldest entry, count stays the same
                    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
                        if (slot_live[i] && slot_age[i] + 1 == live_count) begin
                            slot = i;
                        end
                    end
                    age_younger(live_count - 1);
                end else begin
                    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
                        if (!slot_live[i]) begin
                            slot = i;
                        end
                    end
                    age_younger(live_count);
                    live_count++;
                end
                key_store[slot] = key;
                slot_live[slot] = 1'b1;
                slot_age[slot]  = 0;
            end
        end
        res.hit          = found;
        res.miss_count   = miss_tally;
        res.entries_used = live_count[USED_W-1:0];
        return res;
    endfunction

    task automatic report_error(string msg);
        fail_tally++;
        if (fail_tally <= 10) begin
            $display("%0t: %s", $time, msg);
        end
    endtask

    always @(posedge aclk) begin
        access_result_t want;
        if (!aresetn) begin
            clear_entries();
            miss_tally = '0;
            capacity   = CAP_RESET;
            exp_head   = 0;
            exp_tail   = 0;
            exp_count  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (exp_count == 0) begin
                    report_error($sformatf("result with no request outstanding: tdata %h tuser %b",
                                           m_tdata, m_tuser));
                end else begin
                    want      = expected_results[exp_head];
                    exp_head  = (exp_head + 1) % EXP_DEPTH;
                    exp_count = exp_count - 1;
                    if (m_tuser !== want.hit) begin
                        report_error($sformatf("hit: expected %b, got %b", want.hit, m_tuser));
                    end
                    if (m_tdata[COUNT_W-1:0] !== want.miss_count) begin
                        report_error($sformatf("miss_count: expected %0d, got %0d",
                                               want.miss_count, m_tdata[COUNT_W-1:0]));
                    end
                    if (m_tdata[COUNT_W +: USED_W] !== want.entries_used) begin
                        report_error($sformatf("entries_used: expected %0d, got %0d",
                                               want.entries_used, m_tdata[COUNT_W +: USED_W]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (exp_count == EXP_DEPTH) begin
                    report_error("too many requests outstanding");
                end else begin
                    expected_results[exp_tail] = access_cache(s_tdata[KEY_W-1:0], s_tuser);
                    exp_tail  = (exp_tail + 1) % EXP_DEPTH;
                    exp_count = exp_count + 1;
                end
            end
            if (cfg_wr_en) begin
                capacity = cfg_wr_data;
            end
        end
        pending_results = exp_count;
    end

endmodule

// ===== bench/lru_miss_counter_tb.sv =====
// testbench top for the lru miss counter: clock, reset, capacity writes and
// key requests with random stalls on both channels, plus the final verdict
// depends on lmc_pkg, lru_miss_counter and lru_miss_counter_check
module lru_miss_counter_tb;
    import lmc_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 112;
    localparam int POOL_SIZE       = 32;
    localparam logic [CAP_W-1:0] CAP_PLAN [11] = '{
        5'd16, 5'd3, 5'd31, 5'd1, 5'd8, 5'd17, 5'd0, 5'd5, 5'd12, 5'd2, 5'd16
    };

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic                m_tuser;
    logic                cfg_wr_en;
    logic [CAP_W-1:0]    cfg_wr_data;
    int                  fail_count;
    int                  pending_results;
    int unsigned         cycle_count = 0;
    logic                calm = 1'b0;
    logic [KEY_W-1:0]    key_pool [POOL_SIZE];

    lru_miss_counter uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lru_miss_counter_check miss_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side stalls in bursts, none in the calm stretch
    initial begin
        m_tready = 1'b0;
        @(negedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 2) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    // entered and left at a falling edge
    task automatic send_access(input logic [KEY_W-1:0] key, input logic start);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        s_tuser  <= start;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= cap;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end
    endtask

    initial begin
        int unsigned      span;
        int unsigned      eff_cap;
        logic [KEY_W-1:0] pick;
        logic             start;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        refresh_pool();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset capacity, hits and a new sequence
        send_access(32'h0000_0000, 1'b1);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h8000_0001, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        // two entries, eviction of the oldest
        set_capacity(5'd2);
        send_access(32'hA5A5_A5A5, 1'b0);
        send_access(32'h5A5A_5A5A, 1'b0);
        send_access(32'hA5A5_A5A5, 1'b0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h5A5A_5A5A, 1'b0);
        // zero capacity: always a miss, contents kept, then a new sequence
        set_capacity(5'd0);
        send_access(32'h0000_0000, 1'b0);
        send_access(32'h0000_0000, 1'b1);
        // above the maximum acts as the maximum
        set_capacity(5'd31);
        send_access(32'h0000_0001, 1'b0);
        send_access(32'h0000_0002, 1'b0);
        send_access(32'h0000_0003, 1'b0);
        send_access(32'h0000_0001, 1'b0);
        // capacity lowered below the entries in use
        set_capacity(5'd1);
        send_access(32'h0000_0004, 1'b0);
        send_access(32'h0000_0001, 1'b0);
        send_access(32'h0000_0003, 1'b0);
        send_access(32'h0000_0005, 1'b0);

        foreach (CAP_PLAN[p]) begin
            if (p == $size(CAP_PLAN) - 1) begin
                calm = 1'b1;
            end
            set_capacity(CAP_PLAN[p]);
            if ($urandom_range(0, 2) == 0) begin
                refresh_pool();
            end
            eff_cap = (CAP_PLAN[p] > MAX_ENTRIES) ? MAX_ENTRIES : CAP_PLAN[p];
            span    = eff_cap + $urandom_range(1, 6);
            if (span > POOL_SIZE) begin
                span = POOL_SIZE;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pick = $urandom;
                end else begin
                    pick = key_pool[$urandom_range(0, span - 1)];
                end
                if (n == 0) begin
                    start = ($urandom_range(0, 2) == 0);
                end else begin
                    start = ($urandom_range(0, 49) == 0);
                end
                send_access(pick, start);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
